// ===== rtl/bimf_pkg.sv =====
// Shared types and constants of the binary image majority filter.
package bimf_pkg;

	// Input opcodes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Register index, taken from address bit 2.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Register reset values before clamping.
	localparam int unsigned RESET_WIDTH  = 128;
	localparam int unsigned RESET_HEIGHT = 64;

	// Field widths of the registers and of a result word.
	localparam int unsigned CFG_WIDTH_W  = 8;
	localparam int unsigned CFG_HEIGHT_W = 7;
	localparam int unsigned OUT_ROW_W    = 6;
	localparam int unsigned OUT_COL_W    = 7;

	// One column of the two line stores.
	typedef struct packed {
		logic upper;
		logic lower;
	} line_pair_t;

	// Where the centre pixel lies against the image border.
	typedef struct packed {
		logic first_row;
		logic last_row;
		logic first_col;
		logic last_col;
	} pos_flags_t;

	// One result word.
	typedef struct packed {
		logic                 pixel;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic                 last;
	} out_word_t;

endpackage

// ===== rtl/bimf_cell.sv =====
// One column cell of the line stores: holds an upper and a lower line bit.
module bimf_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned SELW  = 7
) (
	input  logic                   clk,
	input  logic                   shift,
	input  logic [SELW-1:0]        sel,
	input  bimf_pkg::line_pair_t   prev,
	input  bimf_pkg::line_pair_t   fresh,
	output bimf_pkg::line_pair_t   bits
);
	import bimf_pkg::*;

	line_pair_t bits_q;
	logic       head;

	// The cell at the insertion point takes the new column, the others take their neighbour's.
	assign head = (sel == SELW'(INDEX));

	always_ff @(posedge clk) begin
		if (shift) begin
			bits_q <= head ? fresh : prev;
		end
	end

	assign bits = bits_q;

endmodule

// ===== rtl/bimf_line_chain.sv =====
// Row of column cells forming both line stores as a delay line of adjustable length.
module bimf_line_chain #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned SELW  = 7
) (
	input  logic                   clk,
	input  logic                   shift,
	input  logic [SELW-1:0]        sel,
	input  bimf_pkg::line_pair_t   fresh,
	output bimf_pkg::line_pair_t   tail
);
	import bimf_pkg::*;

	line_pair_t link [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			bimf_cell #(.INDEX(i), .SELW(SELW)) u_cell (
				.clk   (clk),
				.shift (shift),
				.sel   (sel),
				.prev  (fresh),
				.fresh (fresh),
				.bits  (link[i])
			);
		end else begin : g_rest
			bimf_cell #(.INDEX(i), .SELW(SELW)) u_cell (
				.clk   (clk),
				.shift (shift),
				.sel   (sel),
				.prev  (link[i-1]),
				.fresh (fresh),
				.bits  (link[i])
			);
		end
	end

	assign tail = link[DEPTH-1];

endmodule

// ===== rtl/bimf_vote.sv =====
// 3x3 window register and the neighbour majority decision.
module bimf_vote (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic [2:0]             newcol,
	input  bimf_pkg::pos_flags_t   flags,
	output logic                   vote
);
	import bimf_pkg::*;

	logic [8:0] win_q;
	logic [8:0] win_d;
	logic [8:0] mask;
	logic [3:0] sum;
	logic [3:0] cnt;

	// Column k of the window sits at bits 3k+2..3k, row j at bit 3k+j; column 2 is the newest.
	assign win_d = shift ? {newcol, win_q[8:3]} : win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else begin
			win_q <= win_d;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				mask[k*3+j] = !((k == 0 && flags.first_col) || (k == 2 && flags.last_col) ||
					(j == 0 && flags.first_row) || (j == 2 && flags.last_row) ||
					(k == 1 && j == 1));
			end
		end
		sum  = 4'($countones(win_d & mask));
		cnt  = 4'($countones(mask));
		vote = (sum > (cnt >> 1));
	end

endmodule

// ===== rtl/binary_image_majority_filter.sv =====
// Top level of the streaming 3x3 binary majority filter with its register port and output queue.
//
// The filter takes a binary image in raster order, one pixel word per clock while input ready
// is high, and returns, for each pixel, a 1 when more than half of its in-image neighbours are
// set (the centre itself does not vote, and neighbours outside the image are not counted).
// Each word taken is handled by the row of column cells that forms the two line stores and by
// the window register, and the result it yields is registered into the output queue.
// Results run one row plus one pixel behind the input, so the first result follows
// the pixel word at column 1 of row 1 (the third pixel word for a one-pixel-wide image), and
// the tail of an image is pushed out by drain words (or by further pixel words, whose pixels
// are then thrown away). A drain word sent before the image is complete is taken and ignored.
// A two-word output queue lets the input side keep taking words while a result waits; input
// ready falls only when both queue entries are full. Writing either register restarts the
// frame; registers must only be written while the filter is idle. A register value of 0 acts
// as 1 and a value above the supported maximum acts as that maximum.
module binary_image_majority_filter #(
	parameter int unsigned MAX_COLS = 128,
	parameter int unsigned MAX_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input words.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic        pixel_in,
	// Result words.
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pixel_out,
	output logic [bimf_pkg::OUT_ROW_W-1:0] out_row,
	output logic [bimf_pkg::OUT_COL_W-1:0] out_col,
	output logic        frame_last,
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bimf_pkg::*;

	// Largest widths and heights the register fields can reach.
	localparam int unsigned WMAX = (MAX_COLS < 255) ? MAX_COLS : 255;
	localparam int unsigned HMAX = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int unsigned WW   = $clog2(WMAX + 1);
	localparam int unsigned HW   = $clog2(HMAX + 1);
	localparam int unsigned CW   = $clog2(WMAX);
	localparam int unsigned RW   = $clog2(HMAX);
	localparam int unsigned WRST = (RESET_WIDTH < WMAX) ? RESET_WIDTH : WMAX;
	localparam int unsigned HRST = (RESET_HEIGHT < HMAX) ? RESET_HEIGHT : HMAX;

	// Registers.
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [WW-1:0] width_new;
	logic [HW-1:0] height_new;
	logic [CFG_WIDTH_W-1:0]  wval;
	logic [CFG_HEIGHT_W-1:0] hval;
	logic          cfg_wr;
	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;
	logic [CW-1:0] sel;

	// Positions.
	logic [CW-1:0] in_col_q;
	logic [HW-1:0] in_row_q;
	logic          primed_q;
	logic [CW-1:0] ocol_q;
	logic [RW-1:0] orow_q;

	// Datapath.
	logic          in_acc;
	logic          past_end;
	logic          advance;
	logic          px;
	logic          emit;
	logic          o_last;
	line_pair_t    tail;
	line_pair_t    fresh;
	pos_flags_t    flags;
	logic          vote;

	// Output queue.
	logic [1:0]    cnt_q;
	out_word_t     slot0_q;
	out_word_t     slot1_q;
	out_word_t     new_word;
	logic          pop;

	// ---------------------------------------------------------------- register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign wval   = pwdata[CFG_WIDTH_W-1:0];
	assign hval   = pwdata[CFG_HEIGHT_W-1:0];

	// Clamp written values into the supported range.
	always_comb begin
		if (wval == '0) begin
			width_new = WW'(1);
		end else if (32'(wval) > 32'(WMAX)) begin
			width_new = WW'(WMAX);
		end else begin
			width_new = WW'(wval);
		end
		if (hval == '0) begin
			height_new = HW'(1);
		end else if (32'(hval) > 32'(HMAX)) begin
			height_new = HW'(HMAX);
		end else begin
			height_new = HW'(hval);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(WRST);
			height_q <= HW'(HRST);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= width_new;
				REG_HEIGHT: height_q <= height_new;
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	assign wm1 = CW'(width_q - WW'(1));
	assign hm1 = RW'(height_q - HW'(1));
	// The line stores are as long as a row: new columns enter that many cells before the tail.
	assign sel = CW'(WW'(WMAX) - width_q);

	// ---------------------------------------------------------------- input side
	assign in_ready = (cnt_q != 2'd2);
	assign in_acc   = in_valid && in_ready;
	// Once the whole image is in, every word only pushes a blank pixel through.
	assign past_end = (in_row_q == height_q);
	assign advance  = in_acc && (past_end || (opcode != OP_DRAIN));
	assign px       = past_end ? 1'b0 : pixel_in;
	// A result is due once the input is one row plus one pixel ahead.
	assign emit     = advance && primed_q;
	assign o_last   = (orow_q == hm1) && (ocol_q == wm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			primed_q <= 1'b0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else if (cfg_wr || (emit && o_last)) begin
			// A register write or the final result of an image starts a new frame.
			in_col_q <= '0;
			in_row_q <= '0;
			primed_q <= 1'b0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else if (advance) begin
			if (in_col_q == wm1) begin
				in_col_q <= '0;
				if (!past_end) begin
					in_row_q <= in_row_q + HW'(1);
				end
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
			if (in_row_q == HW'(1) && in_col_q == '0) begin
				primed_q <= 1'b1;
			end
			if (emit) begin
				if (ocol_q == wm1) begin
					ocol_q <= '0;
					orow_q <= orow_q + RW'(1);
				end else begin
					ocol_q <= ocol_q + CW'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------- line stores and window
	// The lower store takes the new pixel and hands its old bit up to the upper store.
	assign fresh.upper = tail.lower;
	assign fresh.lower = px;

	bimf_line_chain #(.DEPTH(WMAX), .SELW(CW)) u_chain (
		.clk   (clk),
		.shift (advance),
		.sel   (sel),
		.fresh (fresh),
		.tail  (tail)
	);

	assign flags.first_row = (orow_q == '0);
	assign flags.last_row  = (orow_q == hm1);
	assign flags.first_col = (ocol_q == '0);
	assign flags.last_col  = (ocol_q == wm1);

	bimf_vote u_vote (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (advance),
		.newcol ({px, tail.lower, tail.upper}),
		.flags  (flags),
		.vote   (vote)
	);

	// ---------------------------------------------------------------- output queue
	assign new_word.pixel = vote;
	assign new_word.row   = OUT_ROW_W'(orow_q);
	assign new_word.col   = OUT_COL_W'(ocol_q);
	assign new_word.last  = o_last;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({emit, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({emit, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					slot0_q <= new_word;
				end else begin
					slot1_q <= new_word;
				end
			end
			2'b01: slot0_q <= slot1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					slot0_q <= new_word;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= new_word;
				end
			end
			default: ;
		endcase
	end

	assign pixel_out  = slot0_q.pixel;
	assign out_row    = slot0_q.row;
	assign out_col    = slot0_q.col;
	assign frame_last = slot0_q.last;

	// ---------------------------------------------------------------- assertions
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && o_last) |=> (ocol_q == '0 && orow_q == '0 && in_row_q == '0 && !primed_q))
		else $error("positions not cleared after the last result of an image");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ocol_q <= wm1) && (in_col_q <= wm1))
		else $error("column position beyond the image width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= height_q)
		else $error("input row position beyond the image height");

	a_idle_output: assert property (@(posedge clk) disable iff (!arst_n)
		!primed_q |-> (ocol_q == '0 && orow_q == '0))
		else $error("output position moved before the pipeline was primed");

endmodule

// ===== tb/sv/bimf_checker.sv =====
// Checker for the binary majority filter: predicts every filtered pixel and compares the results.
`timescale 1ns / 100ps

module bimf_checker #(
	parameter int unsigned COLS = 128,
	parameter int unsigned ROWS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           opcode,
	input  logic                           pixel_in,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           pixel_out,
	input  logic [bimf_pkg::OUT_ROW_W-1:0] out_row,
	input  logic [bimf_pkg::OUT_COL_W-1:0] out_col,
	input  logic                           frame_last,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             pending,
	output int                             results_checked,
	output int                             frames_closed
);
	import bimf_pkg::*;

	// Own copy of the filter state.
	bit          row_above [COLS];
	bit          row_below [COLS];
	bit [8:0]    window = '0;
	int unsigned pixels_taken = 0;
	int unsigned pixels_filtered = 0;
	int unsigned img_w = COLS;
	int unsigned img_h = ROWS;

	out_word_t   filtered_pending [$];
	out_word_t   oldest;
	out_word_t   predicted;
	int          fails = 0;
	int          checked = 0;
	int          closed = 0;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned ceiling);
		if (v == 0)
			return 1;
		return (v > ceiling) ? ceiling : v;
	endfunction

	// Takes one word into the window; returns 1 when it yields a filtered pixel.
	function automatic bit shift_in_pixel(input logic op, input logic px_in,
	                                      output out_word_t res);
		int unsigned total, q, p, r, c, slot, votes, voters;
		bit          px, up, lo;
		total = img_w * img_h;
		q = pixels_taken;
		res = '0;
		if (q >= total)
			px = 1'b0;
		else if (op == OP_DRAIN)
			return 1'b0;
		else
			px = px_in;
		slot = q % img_w;
		up = row_above[slot];
		lo = row_below[slot];
		row_above[slot] = lo;
		row_below[slot] = px;
		window = {px, lo, up, window[8:3]};
		if (q < img_w + 1) begin
			pixels_taken = q + 1;
			return 1'b0;
		end
		p = pixels_filtered;
		r = p / img_w;
		c = p % img_w;
		votes = 0;
		voters = 0;
		for (int k = 0; k < 3; k++) begin
			if ((k == 0 && c == 0) || (k == 2 && c + 1 >= img_w))
				continue;
			for (int j = 0; j < 3; j++) begin
				if ((j == 0 && r == 0) || (j == 2 && r + 1 >= img_h) || (j == 1 && k == 1))
					continue;
				voters++;
				votes += window[k*3 + j];
			end
		end
		res.pixel = (votes > voters / 2);
		res.row   = r[OUT_ROW_W-1:0];
		res.col   = c[OUT_COL_W-1:0];
		res.last  = (p + 1 == total);
		if (p + 1 == total) begin
			pixels_taken = 0;
			pixels_filtered = 0;
		end else begin
			pixels_taken = q + 1;
			pixels_filtered = p + 1;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (row_above[i]) begin
				row_above[i] = 1'b0;
				row_below[i] = 1'b0;
			end
			window = '0;
			pixels_taken = 0;
			pixels_filtered = 0;
			img_w = clamp_dim(RESET_WIDTH, COLS);
			img_h = clamp_dim(RESET_HEIGHT, ROWS);
			filtered_pending.delete();
			pending <= 0;
		end else begin
			// The result of a word shows up only after the word is taken, so results go first.
			if (out_valid && out_ready) begin
				if (filtered_pending.size() == 0) begin
					$error("Result with none expected: pixel_out %0d row %0d col %0d last %0d",
					       pixel_out, out_row, out_col, frame_last);
					fails++;
				end else begin
					oldest = filtered_pending.pop_front();
					checked++;
					if (oldest.last)
						closed++;
					if (pixel_out !== oldest.pixel) begin
						$error("pixel_out: expected %0d, got %0d", oldest.pixel, pixel_out);
						fails++;
					end
					if (out_row !== oldest.row) begin
						$error("out_row: expected %0d, got %0d", oldest.row, out_row);
						fails++;
					end
					if (out_col !== oldest.col) begin
						$error("out_col: expected %0d, got %0d", oldest.col, out_col);
						fails++;
					end
					if (frame_last !== oldest.last) begin
						$error("frame_last: expected %0d, got %0d", oldest.last, frame_last);
						fails++;
					end
				end
			end
			// Any register write restarts the frame; the line stores keep their bits.
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_WIDTH)
					img_w = clamp_dim(pwdata[CFG_WIDTH_W-1:0], COLS);
				else
					img_h = clamp_dim(pwdata[CFG_HEIGHT_W-1:0], ROWS);
				pixels_taken = 0;
				pixels_filtered = 0;
			end
			if (in_valid && in_ready) begin
				if (shift_in_pixel(opcode, pixel_in, predicted))
					filtered_pending.push_back(predicted);
			end
			pending <= filtered_pending.size();
		end
		fail_count      <= fails;
		results_checked <= checked;
		frames_closed   <= closed;
	end

endmodule

// ===== tb/sv/tb_binary_image_majority_filter.sv =====
// Testbench top of the binary majority filter: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_binary_image_majority_filter;
	import bimf_pkg::*;

	localparam int unsigned MAX_W       = 128;
	localparam int unsigned MAX_H       = 64;
	localparam int          ITEM_TARGET = 1850;
	localparam int          HOLD_CYCLES = 120;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          TAIL_CYCLES = 10;
	localparam int          TIMEOUT_NS  = 2_000_000;

	// Flow-control phases of the run.
	typedef enum int {
		FLOW_FREE,
		FLOW_TX_IDLE,
		FLOW_RX_STALL,
		FLOW_BOTH
	} flow_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 opcode = OP_PIXEL;
	logic                 pixel_in = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 pixel_out;
	logic [OUT_ROW_W-1:0] out_row;
	logic [OUT_COL_W-1:0] out_col;
	logic                 frame_last;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [2:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	int fail_count;
	int pending_results;
	int results_checked;
	int frames_closed;

	// Percentages of idle cycles on each side. rx_pct is read by the receiver process at the
	// clock edge, so it is only ever changed with a nonblocking assignment.
	int tx_pct = 0;
	int rx_pct = 0;

	// A long receiver hold-off is requested by bumping hold_seq; the receiver notices the
	// change and counts the stretch down itself.
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int words_sent = 0;
	int items = 0;
	int reg_writes = 0;

	always #5 clk = ~clk;

	binary_image_majority_filter #(
		.MAX_COLS(MAX_W),
		.MAX_ROWS(MAX_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.out_row   (out_row),
		.out_col   (out_col),
		.frame_last(frame_last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	bimf_checker #(
		.COLS(MAX_W),
		.ROWS(MAX_H)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.pixel_in       (pixel_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_out      (pixel_out),
		.out_row        (out_row),
		.out_col        (out_col),
		.frame_last     (frame_last),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.pending        (pending_results),
		.results_checked(results_checked),
		.frames_closed  (frames_closed)
	);

	// Receiver: a fresh hold-off request wins, then any hold-off still running, and otherwise
	// ready is drawn at random according to the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (rx_pct == 0) || ($urandom_range(0, 99) >= rx_pct);
		end
	end

	// Sets the idle percentages of both sides for the phase given.
	task automatic set_flow(input flow_t phase);
		case (phase)
			FLOW_FREE: begin
				tx_pct = 0;
				rx_pct <= 0;
			end
			FLOW_TX_IDLE: begin
				tx_pct = 53;
				rx_pct <= 0;
			end
			FLOW_RX_STALL: begin
				tx_pct = 0;
				rx_pct <= 53;
			end
			default: begin
				tx_pct = 22;
				rx_pct <= 22;
			end
		endcase
	endtask

	// Offers one word and returns at the edge where it is taken. Idle cycles are drawn first,
	// so valid is only lowered when a gap really follows; back-to-back words keep it high.
	task automatic send_word(input logic op, input logic px);
		int gap;
		gap = 0;
		while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		pixel_in <= px;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	// Stops sending and waits until every predicted result has been taken. The first edge
	// lets the checker's count catch up with the word taken at the current edge.
	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	// Words that yield no result may still be inside the block when the last result has left,
	// so the bench waits on before the registers are touched.
	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: a setup cycle, an access cycle, then the bus goes idle
	// so that a following write never changes psel twice in one step.
	task automatic write_reg(input logic idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// Programs an image size. Where odd_code is set, a width or height of 1 may be written as
	// 0 and the maximum as a value above it, which the block must clamp. Bits above each field
	// carry random junk that the block must ignore.
	task automatic program_geometry(input int unsigned w, input int unsigned h,
	                                input bit odd_code);
		logic [31:0] wdat;
		logic [31:0] hdat;
		wdat = $urandom;
		hdat = $urandom;
		if (odd_code && w == 1)
			wdat[7:0] = 8'd0;
		else if (odd_code && w == MAX_W)
			wdat[7:0] = 8'($urandom_range(MAX_W + 1, 255));
		else
			wdat[7:0] = 8'(w);
		if (odd_code && h == 1)
			hdat[6:0] = 7'd0;
		else if (odd_code && h == MAX_H)
			hdat[6:0] = 7'($urandom_range(MAX_H + 1, 127));
		else
			hdat[6:0] = 7'(h);
		if ($urandom_range(0, 1)) begin
			write_reg(REG_WIDTH, wdat);
			write_reg(REG_HEIGHT, hdat);
		end else begin
			write_reg(REG_HEIGHT, hdat);
			write_reg(REG_WIDTH, wdat);
		end
	endtask

	initial begin : stimulus
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned stop_at;
		int unsigned density;
		bit          broken;
		bit [8:0]    pattern;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_flow(FLOW_FREE);

		// Directed part. Under the reset size of 128 by 64 a few pixels go in, with a drain
		// among them that must be ignored since the image is far from complete.
		send_word(OP_PIXEL, 1'b1);
		send_word(OP_PIXEL, 1'b0);
		send_word(OP_DRAIN, 1'b1);
		send_word(OP_PIXEL, 1'b1);
		items += 3;
		settle();

		// Zero in both registers acts as a one-pixel image and restarts the half-done frame.
		// Bit 7 of the height word lies outside the field.
		write_reg(REG_WIDTH, 32'h0000_0000);
		write_reg(REG_HEIGHT, 32'hFFFF_FF80);
		// The second pixel word arrives after the whole image, so it acts as a drain; the
		// drain after it brings out the single result, and the last drain opens a new frame
		// and is ignored.
		send_word(OP_PIXEL, 1'b1);
		send_word(OP_PIXEL, 1'b0);
		send_word(OP_DRAIN, 1'b0);
		send_word(OP_DRAIN, 1'b1);
		items += 3;
		settle();

		// Values above the maximum clamp to it; then a 3 by 3 image with junk in the high bits.
		write_reg(REG_WIDTH, 32'h0000_00FF);
		write_reg(REG_HEIGHT, 32'h0000_007F);
		write_reg(REG_WIDTH, 32'hFFFF_FF03);
		write_reg(REG_HEIGHT, 32'hFFFF_FF83);
		pattern = 9'b110_101_011;
		for (int i = 0; i < 9; i++) begin
			if (i == 4)
				send_word(OP_DRAIN, 1'b1);
			send_word(OP_PIXEL, pattern[i]);
		end
		// The tail is a row plus one pixel: drains, with one pixel word standing in for one.
		send_word(OP_DRAIN, 1'b0);
		send_word(OP_PIXEL, 1'b1);
		send_word(OP_DRAIN, 1'b1);
		send_word(OP_DRAIN, 1'b0);
		items += 13;

		// Random part: mostly whole, well-formed images of random content and size, with
		// stray drains, early pauses and cut-off frames as noise. The flow phase changes
		// every five frames. Frame 0 runs into a long receiver hold-off with the sender busy,
		// and frames 1 and 2 take the widest and the tallest images.
		for (int frame_no = 0; items < ITEM_TARGET; frame_no++) begin
			settle();
			set_flow(flow_t'((frame_no / 5) % 4));
			if (frame_no == 0) begin
				w = 6;
				h = 5;
			end else if (frame_no == 1) begin
				w = MAX_W;
				h = 2;
			end else if (frame_no == 2) begin
				w = 1;
				h = MAX_H;
			end else if ($urandom_range(0, 14) == 0) begin
				if ($urandom_range(0, 1)) begin
					w = $urandom_range(100, MAX_W);
					h = $urandom_range(1, 2);
				end else begin
					w = $urandom_range(1, 3);
					h = $urandom_range(40, MAX_H);
				end
			end else begin
				w = $urandom_range(1, 10);
				h = $urandom_range(1, 8);
			end
			program_geometry(w, h, frame_no < 3 || $urandom_range(0, 1));
			total   = w * h;
			density = $urandom_range(0, 100);
			broken  = frame_no > 2 && $urandom_range(0, 9) == 0;
			stop_at = broken ? $urandom_range(0, total + w) : total + w + 1;
			if (frame_no == 0 || $urandom_range(0, 19) == 0)
				hold_seq <= hold_seq + 1;
			for (int n = 0; n < stop_at; n++) begin
				if (n < total) begin
					if ($urandom_range(0, 29) == 0)
						send_word(OP_DRAIN, 1'($urandom_range(0, 1)));
					if ($urandom_range(0, 149) == 0)
						wait_results();
					send_word(OP_PIXEL, $urandom_range(0, 99) < density);
				end else begin
					send_word($urandom_range(0, 9) < 7 ? OP_DRAIN : OP_PIXEL,
					          1'($urandom_range(0, 1)));
				end
				items++;
			end
		end

		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display(
			"Sent %0d words (%0d items), %0d register writes; %0d results in %0d frames,",
			words_sent, items, reg_writes, results_checked, frames_closed);
		$display(
			"under free flow, sender idling, receiver stalling, both, and long hold-offs.");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Guards against a hang anywhere in the run.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Run timed out with %0d results outstanding.", pending_results);
		$display("Test completed with failures");
		$finish;
	end

endmodule
